// ===== sv/bfhp_pkg.sv =====
package bfhp_pkg;

  typedef enum logic [10:0] {
    PH_MAGIC   = 11'b000_0000_0001,
    PH_PCHAR   = 11'b000_0000_0010,
    PH_ECHAR   = 11'b000_0000_0100,
    PH_VERSION = 11'b000_0000_1000,
    PH_CODE    = 11'b000_0001_0000,
    PH_SIZE    = 11'b000_0010_0000,
    PH_PTR     = 11'b000_0100_0000,
    PH_INDEX   = 11'b000_1000_0000,
    PH_COUNT   = 11'b001_0000_0000,
    PH_DATA    = 11'b010_0000_0000,
    PH_HALT    = 11'b100_0000_0000
  } phase_t;

  localparam logic [2:0] KIND_HDR_OK    = 3'd0;
  localparam logic [2:0] KIND_BLOCK     = 3'd1;
  localparam logic [2:0] KIND_END       = 3'd2;
  localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
  localparam logic [2:0] KIND_BAD_TYPE  = 3'd4;

  localparam logic [7:0] CH_PTR32  = 8'h5F;
  localparam logic [7:0] CH_PTR64  = 8'h2D;
  localparam logic [7:0] CH_LITTLE = 8'h76;
  localparam logic [7:0] CH_BIG    = 8'h56;

  localparam logic [2:0]  MAGIC_LAST = 3'd6;
  localparam logic [31:0] END_CODE   = 32'h454E_4442;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  file_type;
    logic [31:0] code_word;
    logic [31:0] data_size;
    logic [63:0] prev_pointer;
    logic [31:0] sdna_index;
    logic [31:0] struct_count;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h42;
      3'd1:    val = 8'h4C;
      3'd2:    val = 8'h45;
      3'd3:    val = 8'h4E;
      3'd4:    val = 8'h44;
      3'd5:    val = 8'h45;
      3'd6:    val = 8'h52;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] shift32(input logic [31:0] r, input logic [7:0] b,
                                          input logic big);
    return big ? {r[23:0], b} : {b, r[31:8]};
  endfunction

  function automatic logic [63:0] shift64(input logic [63:0] r, input logic [7:0] b,
                                          input logic big);
    return big ? {r[55:0], b} : {b, r[63:8]};
  endfunction

endpackage

// ===== sv/bfhp_in_if.sv =====
interface bfhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ===== sv/bfhp_out_if.sv =====
interface bfhp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  file_type;
  logic [31:0] code_word;
  logic [31:0] data_size;
  logic [63:0] prev_pointer;
  logic [31:0] sdna_index;
  logic [31:0] struct_count;

  modport source (output valid, output kind, output file_type, output code_word,
                  output data_size, output prev_pointer, output sdna_index,
                  output struct_count, input ready);
  modport sink   (input valid, input kind, input file_type, input code_word,
                  input data_size, input prev_pointer, input sdna_index,
                  input struct_count, output ready);
endinterface

// ===== sv/bfhp_out_stage.sv =====
module bfhp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bfhp_pkg::result_t res,
  output logic              can_load,
  bfhp_out_if.source        out_chan
);
  import bfhp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.kind         = data_r.kind;
  assign out_chan.file_type    = data_r.file_type;
  assign out_chan.code_word    = data_r.code_word;
  assign out_chan.data_size    = data_r.data_size;
  assign out_chan.prev_pointer = data_r.prev_pointer;
  assign out_chan.sdna_index   = data_r.sdna_index;
  assign out_chan.struct_count = data_r.struct_count;

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load) else $error("result loaded over a pending transaction");

  a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_chan.ready && !load |=> !valid_r)
    else $error("result register not released");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_chan.ready |=> valid_r && $stable(data_r))
    else $error("stalled result lost");

endmodule

// ===== sv/tagged_block_file_header_parser_top.sv =====
// Byte-serial block file header parser. One file byte is taken per cycle on
// in_chan; start_of_file restarts parsing at that byte. Each byte updates the
// phase, a field byte counter and at most one field shift register together,
// so a byte can follow every cycle. A descriptor (header ok, block header, end
// block, bad magic, bad type) leaves through a result register in the cycle
// after the byte that completes it; in_chan stalls only while that register
// holds a transaction that out_chan has not taken. Bytes after the end block
// or an error are absorbed with no result until the next start_of_file.
module tagged_block_file_header_parser_top (
  input logic       clk,
  input logic       rst_n,
  bfhp_in_if.sink   in_chan,
  bfhp_out_if.source out_chan
);
  import bfhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  kof_r, kof_nxt;
  logic [1:0]  off_r, off_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] code_r, code_nxt;
  logic [31:0] size_r, size_nxt;
  logic [63:0] ptr_r, ptr_nxt;
  logic [31:0] index_r, index_nxt;
  logic [31:0] count_r, count_nxt;

  phase_t      ph;
  logic [2:0]  cnt;
  logic [1:0]  kof;
  logic [1:0]  off;
  logic [31:0] skip;
  logic [7:0]  b;
  logic        acc;
  logic        can_load;
  logic        res_vld;
  result_t     res;

  assign in_chan.ready = can_load;
  assign acc           = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;

  always_comb begin
    if (in_chan.start_of_file) begin
      ph   = PH_MAGIC;
      cnt  = 3'd0;
      kof  = 2'd0;
      off  = 2'd0;
      skip = 32'd0;
    end else begin
      ph   = phase_r;
      cnt  = cnt_r;
      kof  = kof_r;
      off  = off_r;
      skip = skip_r;
    end

    phase_nxt = ph;
    cnt_nxt   = cnt;
    kof_nxt   = kof;
    off_nxt   = off + 2'd1;
    skip_nxt  = skip;
    code_nxt  = code_r;
    size_nxt  = size_r;
    ptr_nxt   = ptr_r;
    index_nxt = index_r;
    count_nxt = count_r;
    res_vld   = 1'b0;
    res       = '0;

    unique case (ph)
      PH_MAGIC: begin
        if (cnt > MAGIC_LAST || b != magic_byte(cnt)) begin
          phase_nxt = PH_HALT;
          res_vld   = 1'b1;
          res.kind  = KIND_BAD_MAGIC;
        end else if (cnt == MAGIC_LAST) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_PCHAR;
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_PCHAR: begin
        if (b == CH_PTR32 || b == CH_PTR64) begin
          kof_nxt   = {(b == CH_PTR64), 1'b0};
          phase_nxt = PH_ECHAR;
        end else begin
          phase_nxt = PH_HALT;
          res_vld   = 1'b1;
          res.kind  = KIND_BAD_TYPE;
        end
      end
      PH_ECHAR: begin
        if (b == CH_LITTLE || b == CH_BIG) begin
          kof_nxt   = {kof[1], kof[0] | (b == CH_BIG)};
          cnt_nxt   = 3'd0;
          phase_nxt = PH_VERSION;
        end else begin
          phase_nxt = PH_HALT;
          res_vld   = 1'b1;
          res.kind  = KIND_BAD_TYPE;
        end
      end
      PH_VERSION: begin
        if (cnt >= 3'd2) begin
          cnt_nxt       = 3'd0;
          phase_nxt     = PH_CODE;
          res_vld       = 1'b1;
          res.kind      = KIND_HDR_OK;
          res.file_type = kof;
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_CODE: begin
        if (!(cnt == 3'd0 && off != 2'd0)) begin
          code_nxt = {code_r[23:0], b};
          if (cnt >= 3'd3) begin
            cnt_nxt   = 3'd0;
            phase_nxt = PH_SIZE;
          end else begin
            cnt_nxt = cnt + 3'd1;
          end
        end
      end
      PH_SIZE: begin
        size_nxt = shift32(size_r, b, kof[0]);
        if (cnt >= 3'd3) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_PTR;
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_PTR: begin
        ptr_nxt = kof[1] ? shift64(ptr_r, b, kof[0])
                         : {32'd0, shift32(ptr_r[31:0], b, kof[0])};
        if (kof[1] ? (cnt == 3'd7) : (cnt >= 3'd3)) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_INDEX;
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_INDEX: begin
        index_nxt = shift32(index_r, b, kof[0]);
        if (cnt >= 3'd3) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_COUNT;
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_COUNT: begin
        count_nxt = shift32(count_r, b, kof[0]);
        if (cnt >= 3'd3) begin
          cnt_nxt          = 3'd0;
          res_vld          = 1'b1;
          res.file_type    = kof;
          res.code_word    = code_r;
          res.data_size    = size_r;
          res.prev_pointer = ptr_r;
          res.sdna_index   = index_r;
          res.struct_count = count_nxt;
          if (code_r == END_CODE) begin
            res.kind  = KIND_END;
            phase_nxt = PH_HALT;
          end else begin
            res.kind  = KIND_BLOCK;
            skip_nxt  = size_r;
            phase_nxt = (size_r != 32'd0) ? PH_DATA : PH_CODE;
          end
        end else begin
          cnt_nxt = cnt + 3'd1;
        end
      end
      PH_DATA: begin
        if (skip != 32'd0) begin
          skip_nxt = skip - 32'd1;
        end
        if (skip <= 32'd1) begin
          phase_nxt = PH_CODE;
        end
      end
      PH_HALT: begin
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      cnt_r   <= 3'd0;
      kof_r   <= 2'd0;
      off_r   <= 2'd0;
      skip_r  <= 32'd0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      kof_r   <= kof_nxt;
      off_r   <= off_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      code_r  <= code_nxt;
      size_r  <= size_nxt;
      ptr_r   <= ptr_nxt;
      index_r <= index_nxt;
      count_r <= count_nxt;
    end
  end

  bfhp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc && res_vld),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !in_chan.start_of_file && phase_r == PH_HALT |-> !res_vld)
    else $error("result produced while halted");

  a_magic_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MAGIC |-> cnt_r <= MAGIC_LAST)
    else $error("magic byte counter overran");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> skip_r != 32'd0)
    else $error("data phase with nothing to skip");

  a_hdr_to_code: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res_vld && res.kind == KIND_HDR_OK |=> phase_r == PH_CODE && cnt_r == 3'd0)
    else $error("header ok did not enter block code phase");

endmodule
